@@ hdl/cha_pkg.sv @@
package cha_pkg;

    localparam int MAX_HOLES = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_HOLES);
    localparam int CNT_W     = $clog2(MAX_HOLES + 1);
    localparam int STRAT_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    // strategy register codes
    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;
    localparam logic [STRAT_W-1:0] STRAT_NEXT  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STRATEGY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE_COUNT = 1'd1;

    // item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch item, set up scan
        logic scan;     // evaluate one table entry
        logic commit;   // update table, emit result
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
    } status_t;

endpackage

@@ hdl/contiguous_hole_allocator.sv @@
// Contiguous hole allocator: a 16-entry table of hole sizes with first,
// best, worst and next fit placement.
//
// Command channel: an item (func, target_hole, size_value, batch_end) is
// taken at a clock edge with start high and busy low. A load (func 0)
// writes one table entry; an allocate (func 1) places a request.
// Result channel: done is high for exactly one cycle per item and carries
// granted, chosen_hole and hole_left in that beat. The receiver cannot
// stall; the result is simply presented for one cycle.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 strategy,
// 1 hole_count) and cfg_data. cfg_ready is always high; write only idle.
// Timing: a load goes from the accept edge straight to the commit state,
// whose result beat follows. An allocate scans one table entry per cycle
// on a single comparator, examining up to the active hole count (16 max)
// before the commit state; first and next fit stop at the first hit.
// With hole_count 0 an allocate skips the scan and fails. busy falls in the
// cycle done rises, so the next item may be accepted during that beat.
// Reset: table cleared to zero, next-fit pointer 0, strategy first fit,
// hole_count 16; no clearing pass is needed.
module contiguous_hole_allocator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 func,
    input  logic [cha_pkg::IDX_W-1:0]            target_hole,
    input  logic [cha_pkg::SIZE_BITS-1:0]        size_value,
    input  logic                                 batch_end,
    output logic                                 done,
    output logic                                 granted,
    output logic [cha_pkg::IDX_W-1:0]            chosen_hole,
    output logic [cha_pkg::SIZE_BITS-1:0]        hole_left,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cha_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cha_pkg::CFG_DAT_W-1:0]        cfg_data
);

    cha_pkg::ctrl_t   ctrl;
    cha_pkg::status_t status;
    logic             cnt_zero_now;
    logic             ctl_busy;

    // config regs take any beat; the user must keep writes to idle periods, the block does not enforce it
    assign cfg_ready = 1'b1;

    cha_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .func         (func),
        .cnt_zero_now (cnt_zero_now),
        .status       (status),
        .ctrl         (ctrl),
        .busy         (ctl_busy)
    );

    // datapath: table, config, scan counters, pick registers, result beat
    cha_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .cnt_zero_now (cnt_zero_now),
        .func         (func),
        .target_hole  (target_hole),
        .size_value   (size_value),
        .batch_end    (batch_end),
        .cfg_valid    (cfg_valid & cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .granted      (granted),
        .chosen_hole  (chosen_hole),
        .hole_left    (hole_left)
    );

    assign busy = ctl_busy;

endmodule

@@ hdl/cha_ctrl.sv @@
module cha_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             func,
    input  logic             cnt_zero_now,
    input  cha_pkg::status_t status,
    output cha_pkg::ctrl_t   ctrl,
    output logic             busy
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        ctrl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.accept = 1'b1;
                    if (func == cha_pkg::FUNC_LOAD || cnt_zero_now)
                        state_next = ST_COMMIT;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan = 1'b1;
                if (status.scan_done)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                ctrl.commit = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ hdl/cha_dp.sv @@
module cha_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cha_pkg::ctrl_t                       ctrl,
    output cha_pkg::status_t                     status,
    output logic                                 cnt_zero_now,
    input  logic                                 func,
    input  logic [cha_pkg::IDX_W-1:0]            target_hole,
    input  logic [cha_pkg::SIZE_BITS-1:0]        size_value,
    input  logic                                 batch_end,
    input  logic                                 cfg_valid,
    input  logic [cha_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cha_pkg::CFG_DAT_W-1:0]        cfg_data,
    output logic                                 done,
    output logic                                 granted,
    output logic [cha_pkg::IDX_W-1:0]            chosen_hole,
    output logic [cha_pkg::SIZE_BITS-1:0]        hole_left
);

    localparam int IW = cha_pkg::IDX_W;
    localparam int CW = cha_pkg::CNT_W;
    localparam int SW = cha_pkg::SIZE_BITS;

    logic [SW-1:0]                 table_reg [cha_pkg::MAX_HOLES];
    logic [cha_pkg::STRAT_W-1:0]   strategy_reg;
    logic [CW-1:0]                 hole_count_reg;
    logic [IW-1:0]                 ptr_reg;

    logic                          func_reg;
    logic [IW-1:0]                 tgt_reg;
    logic [SW-1:0]                 size_reg;
    logic                          bend_reg;

    logic [IW-1:0]                 j_reg;
    logic [CW-1:0]                 k_reg;
    logic                          found_reg;
    logic [IW-1:0]                 pick_reg;
    logic [SW-1:0]                 pick_val_reg;

    logic                          done_reg;
    logic                          granted_reg;
    logic [IW-1:0]                 chosen_reg;
    logic [SW-1:0]                 left_reg;

    logic [CW-1:0]                 cnt;
    logic [IW-1:0]                 start_j;
    logic [SW-1:0]                 cur_val;
    logic                          fits;
    logic                          take;
    logic                          stop_on_hit;
    logic [CW-1:0]                 j_inc;
    logic [SW-1:0]                 left_calc;

    // effective hole count, saturated at table depth
    assign cnt = (hole_count_reg > CW'(cha_pkg::MAX_HOLES)) ?
                 CW'(cha_pkg::MAX_HOLES) : hole_count_reg;
    assign cnt_zero_now = (cnt == '0);

    assign start_j = (strategy_reg == cha_pkg::STRAT_NEXT && CW'(ptr_reg) < cnt) ?
                     ptr_reg : '0;

    assign cur_val     = table_reg[j_reg];
    assign fits        = (cur_val >= size_reg);
    assign stop_on_hit = (strategy_reg == cha_pkg::STRAT_FIRST) ||
                         (strategy_reg == cha_pkg::STRAT_NEXT);

    always_comb
    begin
        take = 1'b0;
        unique case (strategy_reg)
            cha_pkg::STRAT_BEST:  take = fits && (!found_reg || cur_val < pick_val_reg);
            cha_pkg::STRAT_WORST: take = fits && (!found_reg || cur_val > pick_val_reg);
            default:              take = fits;
        endcase
    end

    assign j_inc = CW'(j_reg) + CW'(1);

    assign status.scan_done = (k_reg + CW'(1) == cnt) || (fits && stop_on_hit);

    assign left_calc = pick_val_reg - size_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg   <= cha_pkg::STRAT_FIRST;
            hole_count_reg <= CW'(cha_pkg::MAX_HOLES);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cha_pkg::REG_STRATEGY:   strategy_reg   <= cfg_data[cha_pkg::STRAT_W-1:0];
                cha_pkg::REG_HOLE_COUNT: hole_count_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // hole table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cha_pkg::MAX_HOLES; i++)
                table_reg[i] <= '0;
        end
        else if (ctrl.commit)
        begin
            if (func_reg == cha_pkg::FUNC_LOAD)
                table_reg[tgt_reg] <= size_reg;
            else if (found_reg)
                table_reg[pick_reg] <= left_calc;
        end
    end

    // next-fit pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= '0;
        else if (ctrl.commit && func_reg == cha_pkg::FUNC_ALLOC)
        begin
            if (bend_reg)
                ptr_reg <= '0;
            else if (found_reg && strategy_reg == cha_pkg::STRAT_NEXT)
                ptr_reg <= pick_reg;
        end
    end

    // item latch and scan registers
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            func_reg <= func;
            tgt_reg  <= target_hole;
            size_reg <= size_value;
            bend_reg <= batch_end;
            j_reg    <= start_j;
            k_reg    <= '0;
        end
        else if (ctrl.scan)
        begin
            j_reg <= (j_inc == cnt) ? '0 : j_inc[IW-1:0];
            k_reg <= k_reg + CW'(1);
        end

        if (ctrl.scan && take)
        begin
            pick_reg     <= j_reg;
            pick_val_reg <= cur_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (ctrl.accept)
            found_reg <= 1'b0;
        else if (ctrl.scan && take)
            found_reg <= 1'b1;
    end

    // result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl.commit;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            if (func_reg == cha_pkg::FUNC_LOAD)
            begin
                granted_reg <= 1'b1;
                chosen_reg  <= tgt_reg;
                left_reg    <= size_reg;
            end
            else
            begin
                granted_reg <= found_reg;
                chosen_reg  <= found_reg ? pick_reg : '0;
                left_reg    <= found_reg ? left_calc : '0;
            end
        end
    end

    assign done        = done_reg;
    assign granted     = granted_reg;
    assign chosen_hole = chosen_reg;
    assign hole_left   = left_reg;

endmodule

@@ hdl/cha_checker.sv @@
module cha_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 func,
    input logic [cha_pkg::IDX_W-1:0]            target_hole,
    input logic [cha_pkg::SIZE_BITS-1:0]        size_value,
    input logic                                 done,
    input logic                                 granted,
    input logic [cha_pkg::IDX_W-1:0]            chosen_hole,
    input logic [cha_pkg::SIZE_BITS-1:0]        hole_left
);

    // accepted item keeps the block busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("item accepted but block not busy");

    // result beat only when the block has finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // failed allocate reports zeros
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !granted) |-> (chosen_hole == '0 && hole_left == '0))
        else $error("refused request with nonzero fields");

    // load echoes its index and size in its result beat
    a_load_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == cha_pkg::FUNC_LOAD) |-> ##2
        (done && granted && chosen_hole == $past(target_hole, 2)
         && hole_left == $past(size_value, 2)))
        else $error("load result mismatch");

endmodule

bind contiguous_hole_allocator cha_checker u_cha_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .target_hole (target_hole),
    .size_value  (size_value),
    .done        (done),
    .granted     (granted),
    .chosen_hole (chosen_hole),
    .hole_left   (hole_left)
);

@@ sim/hole_grant_checker.sv @@
module hole_grant_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          func,
    input  logic [cha_pkg::IDX_W-1:0]     target_hole,
    input  logic [cha_pkg::SIZE_BITS-1:0] size_value,
    input  logic                          batch_end,
    input  logic                          done,
    input  logic                          granted,
    input  logic [cha_pkg::IDX_W-1:0]     chosen_hole,
    input  logic [cha_pkg::SIZE_BITS-1:0] hole_left,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [cha_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cha_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                            errors,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                          granted;
        logic [cha_pkg::IDX_W-1:0]     hole;
        logic [cha_pkg::SIZE_BITS-1:0] left;
    } grant_t;

    // shadow of the block's table and registers
    logic [cha_pkg::SIZE_BITS-1:0] holes [cha_pkg::MAX_HOLES];
    logic [cha_pkg::IDX_W-1:0]     nf_ptr;
    logic [cha_pkg::STRAT_W-1:0]   strat;
    logic [cha_pkg::CFG_DAT_W-1:0] hcount;

    grant_t grants_due [$];

    initial errors = 0;

    task automatic flag(input string what, input int unsigned want,
                        input int unsigned got);
        errors++;
        $display("%0t ns: %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // index of the hole the current strategy picks, -1 on a miss
    function automatic int find_hole(input logic [cha_pkg::SIZE_BITS-1:0] amount);
        int span;
        int pick;
        int first;
        int j;
        span  = (hcount > cha_pkg::MAX_HOLES) ? cha_pkg::MAX_HOLES : int'(hcount);
        pick  = -1;
        if (strat == cha_pkg::STRAT_NEXT)
        begin
            first = (nf_ptr < span) ? int'(nf_ptr) : 0;
            for (int k = 0; k < span; k++)
            begin
                j = (first + k) % span;
                if (pick < 0 && holes[j] >= amount)
                    pick = j;
            end
            if (pick >= 0)
                nf_ptr = cha_pkg::IDX_W'(pick);
        end
        else
        begin
            for (int i = 0; i < span; i++)
            begin
                if (holes[i] >= amount)
                begin
                    case (strat)
                        cha_pkg::STRAT_FIRST: if (pick < 0) pick = i;
                        cha_pkg::STRAT_BEST:
                            if (pick < 0 || holes[i] < holes[pick]) pick = i;
                        default:
                            if (pick < 0 || holes[i] > holes[pick]) pick = i;
                    endcase
                end
            end
        end
        return pick;
    endfunction

    // target_hole is only IDX_W bits wide, so a load always lands in the table
    function automatic grant_t serve_item(input logic f,
                                          input logic [cha_pkg::IDX_W-1:0] tgt,
                                          input logic [cha_pkg::SIZE_BITS-1:0] amount,
                                          input logic last);
        grant_t r;
        int     pick;
        r = '0;
        if (f == cha_pkg::FUNC_LOAD)
        begin
            holes[tgt] = amount;
            r = {1'b1, tgt, amount};
        end
        else
        begin
            pick = find_hole(amount);
            if (pick >= 0)
            begin
                holes[pick] = holes[pick] - amount;
                r = {1'b1, cha_pkg::IDX_W'(pick), holes[pick]};
            end
            if (last)
                nf_ptr = '0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        grant_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < cha_pkg::MAX_HOLES; i++)
                holes[i] = '0;
            nf_ptr = '0;
            strat  = cha_pkg::STRAT_FIRST;
            hcount = cha_pkg::CFG_DAT_W'(cha_pkg::MAX_HOLES);
            grants_due.delete();
            outstanding = 0;
        end
        else
        begin
            // result beat first: an item may be taken in the same cycle
            if (done)
            begin
                if (grants_due.size() == 0)
                    flag("result beat with nothing due", 0, 1);
                else
                begin
                    want = grants_due.pop_front();
                    if (granted !== want.granted)
                        flag("granted", want.granted, granted);
                    if (chosen_hole !== want.hole)
                        flag("chosen_hole", want.hole, chosen_hole);
                    if (hole_left !== want.left)
                        flag("hole_left", want.left, hole_left);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == cha_pkg::REG_STRATEGY)
                    strat = cfg_data[cha_pkg::STRAT_W-1:0];
                else
                    hcount = cfg_data;
            end
            if (start && !busy)
                grants_due.push_back(serve_item(func, target_hole, size_value, batch_end));
            outstanding = grants_due.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // wait for the longest allocate, a scan of all 16 entries, with margin
    localparam int LATENCY    = 20;
    // no beat of any kind within this limit means the block is stuck
    localparam int IDLE_LIMIT = 1000;
    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 44;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          start       = 1'b0;
    logic                          func        = cha_pkg::FUNC_LOAD;
    logic [cha_pkg::IDX_W-1:0]     target_hole = '0;
    logic [cha_pkg::SIZE_BITS-1:0] size_value  = '0;
    logic                          batch_end   = 1'b0;
    logic                          cfg_valid   = 1'b0;
    logic [cha_pkg::CFG_IDX_W-1:0] cfg_index   = cha_pkg::REG_STRATEGY;
    logic [cha_pkg::CFG_DAT_W-1:0] cfg_data    = '0;

    logic                          busy;
    logic                          done;
    logic                          granted;
    logic [cha_pkg::IDX_W-1:0]     chosen_hole;
    logic [cha_pkg::SIZE_BITS-1:0] hole_left;
    logic                          cfg_ready;

    int errors;
    int outstanding;
    int idle_cycles = 0;
    bit no_gaps     = 1'b0;

    always #6 clk = ~clk;

    contiguous_hole_allocator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .target_hole (target_hole),
        .size_value  (size_value),
        .batch_end   (batch_end),
        .done        (done),
        .granted     (granted),
        .chosen_hole (chosen_hole),
        .hole_left   (hole_left),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // predicts and compares every result beat; we only make stimulus here
    hole_grant_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .target_hole (target_hole),
        .size_value  (size_value),
        .batch_end   (batch_end),
        .done        (done),
        .granted     (granted),
        .chosen_hole (chosen_hole),
        .hole_left   (hole_left),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // watchdog: any item, result or register beat restarts the count
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** contiguous_hole_allocator: FAILED **");
            $finish;
        end
    end

    // One command beat. Entered and left on a rising edge. start stays high
    // after the beat so back-to-back items never lower and raise it in one
    // step; it only drops when a gap is drawn or the caller drains.
    // busy is sampled on the falling edge, where it is stable.
    task automatic send_item(input logic f, input logic [cha_pkg::IDX_W-1:0] tgt,
                             input logic [cha_pkg::SIZE_BITS-1:0] amount,
                             input logic last);
        int   gap;
        logic took;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        func        <= f;
        target_hole <= tgt;
        size_value  <= amount;
        batch_end   <= last;
        do
        begin
            @(negedge clk);
            took = !busy;
            @(posedge clk);
        end
        while (!took);
    endtask

    // hold off the sender until every due result has come back, then let
    // the block settle for a full worst-case scan
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    // both registers in one burst; valid stays up between the two beats
    task automatic configure(input logic [cha_pkg::CFG_DAT_W-1:0] strat_data,
                             input logic [cha_pkg::CFG_DAT_W-1:0] count_data);
        logic took;
        for (int r = 0; r < 2; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (r == 0) ? cha_pkg::REG_STRATEGY : cha_pkg::REG_HOLE_COUNT;
            cfg_data  <= (r == 0) ? strat_data : count_data;
            do
            begin
                @(negedge clk);
                took = cfg_ready;
                @(posedge clk);
            end
            while (!took);
        end
        cfg_valid <= 1'b0;
    endtask

    // hole sizes by scale: tight, mid-range, or the full field
    function automatic logic [cha_pkg::SIZE_BITS-1:0] hole_size(input int scale);
        case (scale)
            0:       return cha_pkg::SIZE_BITS'($urandom_range(0, 63));
            1:       return cha_pkg::SIZE_BITS'($urandom_range(0, 4095));
            default: return cha_pkg::SIZE_BITS'($urandom);
        endcase
    endfunction

    initial
    begin
        int                            scale;
        int                            pick;
        logic [cha_pkg::CFG_DAT_W-1:0] count_data;
        logic [cha_pkg::SIZE_BITS-1:0] req;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // reset mode: first fit over all 16 holes, table all zero
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'd0, 1'b0);    // zero request takes an empty hole
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'd1, 1'b1);    // miss, batch end on a miss
        send_item(cha_pkg::FUNC_LOAD, 4'd0, 16'd100, 1'b1);   // batch end on a load does nothing
        send_item(cha_pkg::FUNC_LOAD, 4'd3, 16'd50, 1'b0);
        send_item(cha_pkg::FUNC_LOAD, 4'd7, 16'd50, 1'b0);
        send_item(cha_pkg::FUNC_LOAD, 4'd9, 16'd200, 1'b0);
        send_item(cha_pkg::FUNC_LOAD, 4'd15, 16'hFFFF, 1'b0);
        send_item(cha_pkg::FUNC_ALLOC, 4'd5, 16'd60, 1'b0);   // target ignored on allocate
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'hFFFF, 1'b0); // drains the top hole to zero
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'hFFFF, 1'b0); // nothing fits

        // best fit; upper data bits of the strategy write must be dropped
        drain();
        configure({3'b111, cha_pkg::STRAT_BEST}, 5'd16);
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'd50, 1'b0);   // exact fit, tie to lowest
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'd40, 1'b0);   // exact fit beats larger holes
        send_item(cha_pkg::FUNC_LOAD, 4'd15, 16'hFFFF, 1'b0);

        // worst fit; a count above the table saturates
        drain();
        configure(cha_pkg::CFG_DAT_W'(cha_pkg::STRAT_WORST), 5'd31);
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'd10, 1'b0);
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'hFFFF, 1'b0);

        // next fit: pointer moves with each hit, batch end sends it home
        drain();
        configure(cha_pkg::CFG_DAT_W'(cha_pkg::STRAT_NEXT), 5'd16);
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'd5, 1'b0);
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'd48, 1'b0);
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'd100, 1'b1);
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'd60, 1'b0);   // pointer lands on the top hole

        // shrink the count under the pointer: scan restarts at zero
        drain();
        configure(cha_pkg::CFG_DAT_W'(cha_pkg::STRAT_NEXT), 5'd4);
        send_item(cha_pkg::FUNC_LOAD, 4'd1, 16'd30, 1'b0);
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'd20, 1'b0);
        send_item(cha_pkg::FUNC_LOAD, 4'd12, 16'd500, 1'b0);  // load outside the active range
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'd100, 1'b0);  // must not reach hole 12

        // no active holes: every allocate misses
        drain();
        configure(cha_pkg::CFG_DAT_W'(cha_pkg::STRAT_FIRST), 5'd0);
        send_item(cha_pkg::FUNC_ALLOC, 4'd0, 16'd0, 1'b0);

        // ---- random phases ----
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            pick = $urandom_range(0, 7);
            case (pick)
                0:       count_data = 5'd0;
                1:       count_data = 5'd1;
                2:       count_data = 5'd16;
                3:       count_data = 5'd31;
                default: count_data = cha_pkg::CFG_DAT_W'($urandom_range(0, 31));
            endcase
            configure(cha_pkg::CFG_DAT_W'($urandom), count_data);
            no_gaps = ($urandom_range(0, 3) == 0);
            scale   = $urandom_range(0, 3);

            // refill so the strategies have holes to choose among
            for (int h = 0; h < cha_pkg::MAX_HOLES; h++)
                if ($urandom_range(0, 1) != 0)
                    send_item(cha_pkg::FUNC_LOAD, cha_pkg::IDX_W'(h), hole_size(scale),
                              1'($urandom_range(0, 1)));

            for (int n = 0; n < PHASE_LEN; n++)
            begin
                // an occasional full drain mid-phase
                if ($urandom_range(0, 24) == 0)
                    drain();
                if ($urandom_range(0, 99) < 30)
                    send_item(cha_pkg::FUNC_LOAD, cha_pkg::IDX_W'($urandom),
                              hole_size(scale), 1'($urandom_range(0, 1)));
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5)
                        req = '0;
                    else if (pick < 8)
                        req = '1;
                    else
                    begin
                        case (scale)
                            0:       req = cha_pkg::SIZE_BITS'($urandom_range(0, 15));
                            1:       req = cha_pkg::SIZE_BITS'($urandom_range(0, 1500));
                            default: req = cha_pkg::SIZE_BITS'($urandom);
                        endcase
                    end
                    send_item(cha_pkg::FUNC_ALLOC, cha_pkg::IDX_W'($urandom), req,
                              1'($urandom_range(0, 99) < 15));
                end
            end
        end

        // wait out the last results and a settle window for strays
        drain();
        if (errors == 0)
            $display("** contiguous_hole_allocator: PASSED **");
        else
            $display("** contiguous_hole_allocator: FAILED **");
        $finish;
    end

endmodule

@@ contiguous_hole_allocator.f @@
hdl/cha_pkg.sv
hdl/cha_ctrl.sv
hdl/cha_dp.sv
hdl/contiguous_hole_allocator.sv
hdl/cha_checker.sv
sim/hole_grant_checker.sv
sim/testbench.sv
